>>> design/bgs_pkg.sv
package bgs_pkg;

    localparam int FRAC_BITS_DEF = 8;

    localparam int CURVE_N  = 7;
    localparam int IDX_W    = 3;
    localparam int MV_W     = 15;
    localparam int MA_W     = 16;
    localparam int PCT_W    = 7;
    localparam int WGT_W    = 9;
    localparam int MULB_W   = 9;
    localparam int DIV_NW   = 18;
    localparam int DIV_DW   = 11;
    localparam int DIV_QW   = 7;
    localparam int DIV_CW   = 3;

    localparam logic [WGT_W-1:0] WGT_FULL  = 9'd256;
    localparam logic [WGT_W-1:0] WGT_RESET = 9'd205;
    localparam logic signed [MA_W-1:0] ON_RESET  = -16'sd500;
    localparam logic signed [MA_W-1:0] OFF_RESET = -16'sd100;

    localparam logic [MV_W-1:0] CURVE_MV [CURVE_N] =
        '{15'd12000, 15'd13600, 15'd14000, 15'd14280, 15'd14600, 15'd15000, 15'd16400};
    localparam logic [PCT_W-1:0] CURVE_PC [CURVE_N] =
        '{7'd0, 7'd10, 7'd20, 7'd40, 7'd60, 7'd80, 7'd100};

    typedef enum logic [1:0] {
        REG_WEIGHT = 2'd0,
        REG_ON     = 2'd1,
        REG_OFF    = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic              done;
        logic [DIV_QW-1:0] quot;
    } t_div_stat;

endpackage

>>> design/bgs_mul.sv
module bgs_mul
    import bgs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic signed [FRAC_BITS+16:0]        i_a,
    input  logic        [MULB_W-1:0]            i_b,
    output logic signed [FRAC_BITS+16+MULB_W+1:0] o_prod
);

    logic signed [MULB_W:0] b_s;

    assign b_s = {1'b0, i_b};

    always_ff @(posedge i_clk) begin
        o_prod <= i_a * b_s;
    end

endmodule

>>> design/bgs_div.sv
module bgs_div
    import bgs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_dividend,
    input  logic [DIV_DW-1:0] i_divisor,
    output t_div_stat         o_stat
);

    localparam int SH_W = DIV_DW + DIV_QW - 1;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_NW-1:0] r_rem;
    logic [SH_W-1:0]   r_dsh;
    logic [DIV_QW-1:0] r_quot;
    logic [DIV_NW-1:0] dsh_ext;
    logic              fits;

    assign dsh_ext = DIV_NW'(r_dsh);
    assign fits    = r_rem >= dsh_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_dsh  <= {i_divisor, (DIV_QW-1)'(0)};
            r_quot <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - dsh_ext;
            end
            r_quot <= {r_quot[DIV_QW-2:0], fits};
            r_dsh  <= r_dsh >> 1;
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.quot = r_quot;

endmodule

>>> design/battery_gauge_smoother.sv
// Battery gauge smoother. Each word carries one voltage sample in mV and one signed
// current sample in mA and yields one result word: the smoothed voltage and current
// (exponential average, weight of the old value in 256ths, FRAC_BITS fraction bits),
// a charging flag with hysteresis between two current thresholds, and a charge
// percentage interpolated on a 7-point 4S Li-ion curve. The first sample after reset
// loads the averages directly and reports 0 percent. A sample takes one shared
// multiplier pass per average and a curve search of one point per cycle; an
// interpolated sample then takes one more multiplier pass and a 7-step divider. A
// voltage at or below the lowest curve point or above the highest skips these, and
// the first sample after reset goes straight to the result word.
// The input is not ready while a sample is in work and is ready again in the cycle the
// result word appears. Configuration writes are always ready and should be made while
// the block is idle.
module battery_gauge_smoother
    import bgs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [MV_W-1:0]        i_sample_mv,
    input  logic signed [MA_W-1:0] i_sample_ma,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [MV_W-1:0]        o_smooth_mv,
    output logic signed [MA_W-1:0] o_smooth_ma,
    output logic                   o_charging,
    output logic [PCT_W-1:0]       o_percent,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [15:0]            i_cfg_data
);

    localparam int VW = MV_W + FRAC_BITS;
    localparam int CW = MA_W + FRAC_BITS;
    localparam int MW = CW + 1;
    localparam int PW = MW + MULB_W + 1;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_MULV = 10'b0000000010,
        S_MULC = 10'b0000000100,
        S_ACC  = 10'b0000001000,
        S_HYS  = 10'b0000010000,
        S_SRCH = 10'b0000100000,
        S_MULP = 10'b0001000000,
        S_DIVS = 10'b0010000000,
        S_DIVW = 10'b0100000000,
        S_FIN  = 10'b1000000000
    } t_state;

    t_state r_state;
    logic   r_primed;
    logic   r_flag;
    logic [VW-1:0]        r_volt;
    logic signed [CW-1:0] r_curr;
    logic [MV_W-1:0]      r_smv;
    logic signed [MA_W-1:0] r_sma;
    logic [IDX_W-1:0]     r_idx;
    logic [PCT_W-1:0]     r_pct;
    logic [WGT_W-1:0]     r_weight;
    logic signed [MA_W-1:0] r_on;
    logic signed [MA_W-1:0] r_off;

    logic r_o_valid;
    logic [MV_W-1:0]        r_o_mv;
    logic signed [MA_W-1:0] r_o_ma;
    logic                   r_o_chg;
    logic [PCT_W-1:0]       r_o_pct;

    logic [WGT_W-1:0]     w_clamp;
    logic [MULB_W-1:0]    b_ema;
    logic signed [MW-1:0] mul_a;
    logic [MULB_W-1:0]    mul_b;
    logic signed [PW-1:0] prod;
    logic signed [MW-1:0] delta;
    logic [IDX_W-1:0]     idx_m1;
    logic signed [CW-1:0] on_fx;
    logic signed [CW-1:0] off_fx;
    logic                 v_le;
    logic                 div_start;
    logic [DIV_NW-1:0]    div_num;
    logic [DIV_DW-1:0]    div_den;
    t_div_stat            div_stat;
    logic                 out_free;
    logic                 in_acc;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && o_ready;
    assign out_free    = !r_o_valid || i_ready;

    assign w_clamp = (r_weight > WGT_FULL) ? WGT_FULL : r_weight;
    assign b_ema   = WGT_FULL - w_clamp;
    assign idx_m1  = r_idx - 1'b1;
    assign delta   = prod[MW+7:8];
    assign on_fx   = {r_on, FRAC_BITS'(0)};
    assign off_fx  = {r_off, FRAC_BITS'(0)};
    assign v_le    = r_volt <= {CURVE_MV[r_idx], FRAC_BITS'(0)};

    always_comb begin
        mul_a = '0;
        mul_b = b_ema;
        case (r_state)
            S_MULV: begin
                mul_a = $signed({2'b00, r_smv, FRAC_BITS'(0)}) - $signed({2'b00, r_volt});
            end
            S_MULC: begin
                mul_a = $signed({r_sma[MA_W-1], r_sma, FRAC_BITS'(0)})
                      - $signed({r_curr[CW-1], r_curr});
            end
            S_MULP: begin
                mul_a = $signed({2'b00, r_volt})
                      - $signed({2'b00, CURVE_MV[idx_m1], FRAC_BITS'(0)});
                mul_b = MULB_W'(CURVE_PC[r_idx] - CURVE_PC[idx_m1]);
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    bgs_mul #(
        .FRAC_BITS(FRAC_BITS)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign div_start = (r_state == S_DIVS);
    assign div_num   = prod[FRAC_BITS +: DIV_NW];
    assign div_den   = DIV_DW'(CURVE_MV[r_idx] - CURVE_MV[idx_m1]);

    bgs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_stat     (div_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WGT_RESET;
            r_on     <= ON_RESET;
            r_off    <= OFF_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WEIGHT: r_weight <= i_cfg_data[WGT_W-1:0];
                REG_ON:     r_on     <= $signed(i_cfg_data);
                REG_OFF:    r_off    <= $signed(i_cfg_data);
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_FIN && out_free) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_primed  <= 1'b0;
            r_flag    <= 1'b0;
            r_volt    <= '0;
            r_curr    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_smv <= i_sample_mv;
                        r_sma <= i_sample_ma;
                        if (!r_primed) begin
                            r_volt   <= {i_sample_mv, FRAC_BITS'(0)};
                            r_curr   <= {i_sample_ma, FRAC_BITS'(0)};
                            r_primed <= 1'b1;
                            r_pct    <= '0;
                            if (i_sample_ma < r_on) begin
                                r_flag <= 1'b1;
                            end
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_MULV;
                        end
                    end
                end
                S_MULV: begin
                    r_state <= S_MULC;
                end
                S_MULC: begin
                    r_volt  <= VW'($signed({2'b00, r_volt}) + delta);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_curr  <= CW'($signed({r_curr[CW-1], r_curr}) + delta);
                    r_state <= S_HYS;
                end
                S_HYS: begin
                    if (r_curr > off_fx) begin
                        r_flag <= 1'b0;
                    end else if (r_curr < on_fx) begin
                        r_flag <= 1'b1;
                    end
                    r_idx   <= '0;
                    r_state <= S_SRCH;
                end
                S_SRCH: begin
                    if (v_le) begin
                        if (r_idx == '0) begin
                            r_pct   <= CURVE_PC[0];
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_MULP;
                        end
                    end else if (r_idx == IDX_W'(CURVE_N - 1)) begin
                        r_pct   <= CURVE_PC[CURVE_N-1];
                        r_state <= S_FIN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_MULP: begin
                    r_state <= S_DIVS;
                end
                S_DIVS: begin
                    r_state <= S_DIVW;
                end
                S_DIVW: begin
                    if (div_stat.done) begin
                        r_pct   <= CURVE_PC[idx_m1] + div_stat.quot;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && out_free) begin
            r_o_mv  <= r_volt[VW-1:FRAC_BITS];
            r_o_ma  <= r_curr[CW-1:FRAC_BITS];
            r_o_chg <= r_flag;
            r_o_pct <= r_pct;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_smooth_mv = r_o_mv;
    assign o_smooth_ma = r_o_ma;
    assign o_charging  = r_o_chg;
    assign o_percent   = r_o_pct;

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_percent <= PCT_W'(100)))
        else $error("percent out of range");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready after accepting a word");

    a_div_primed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVW) |-> (r_primed && r_idx != '0))
        else $error("interpolation without a bracketing segment");

endmodule
